// File: sv/expression_lexer_macros.svh
// Assertion macros for the expression lexer RTL.
// Included by exlex_fifo, which checks its own logic; no other dependencies.
`ifndef EXPRESSION_LEXER_MACROS_SVH
`define EXPRESSION_LEXER_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define EXLEX_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("expression_lexer assertion failed");
// Condition that must never be true outside reset.
`define EXLEX_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("expression_lexer forbidden condition seen");
`else
`define EXLEX_ASSERT(lbl, clk, rst_n, prop)
`define EXLEX_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: sv/exlex_pkg.sv
// Shared types, character codes and classification functions of the lexer.
// No dependencies.
package exlex_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int LENGTH_BITS_DEF   = 16;
    localparam int FIFO_DEPTH        = 4;

    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [2:0] {
        K_LPAREN = 3'd0,
        K_RPAREN = 3'd1,
        K_COMMA  = 3'd2,
        K_IDENT  = 3'd3,
        K_INT    = 3'd4,
        K_FLOAT  = 3'd5,
        K_WS     = 3'd6,
        K_UNREC  = 3'd7
    } t_kind;

    // Which of the two result slots an item writes into the queue.
    typedef struct packed {
        logic first;
        logic second;
    } t_push;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic logic is_ident_tail(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_DASH;
    endfunction

endpackage

// File: sv/expression_lexer.sv
// Top level of the byte-serial expression lexer.
// Depends on exlex_pkg, exlex_core and exlex_fifo.
//
// The lexer takes one source byte per item and reports tokens by kind, start
// offset and length; token text is not carried. The accepted byte sits in an
// input register, the lexer state decides its zero, one or two results
// combinationally, and the results go into a four-entry queue that feeds the
// output port. A result is written into the queue when the lexer takes its
// byte. The output hands out one result per cycle while the receiver is
// ready. A byte that closes a token and also emits a one-byte token gives two
// results, but it always leaves the lexer idle, so the byte after it gives at
// most one; with the output always ready the queue absorbs the extra result
// and bytes go at one per cycle without a gap. Only a stalled output slows
// the input: the lexer holds its byte while the queue holds more than two
// results, and once the input register is full ready drops. Positions wrap
// modulo 2^POSITION_BITS and restart at zero after a byte flagged final;
// lengths saturate at all ones and raise length_overflow for that token.
module expression_lexer import exlex_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_char_code,
    input  logic                     i_final_byte,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [2:0]               o_token_kind,
    output logic [POSITION_BITS-1:0] o_start_position,
    output logic [LENGTH_BITS-1:0]   o_token_length,
    output logic                     o_length_overflow,
    output logic                     o_last_of_run
);

    localparam int DATA_BITS = 3 + POSITION_BITS + LENGTH_BITS + 2;

    // input register: hold the accepted byte until the lexer takes it
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_fin;

    logic                 take;
    logic                 room;
    t_push                push;
    logic [DATA_BITS-1:0] data0, data1, head;

    // advance the lexer only when the queue can absorb two results
    assign take    = r_in_valid && room;
    assign o_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // payload needs no reset; load it with every accepted item
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char_code;
            r_fin  <= i_final_byte;
        end
    end

    exlex_core #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_char_code  (r_char),
        .i_final_byte (r_fin),
        .o_push       (push),
        .o_data0      (data0),
        .o_data1      (data1)
    );

    exlex_fifo #(
        .DATA_BITS (DATA_BITS)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 (data0),
        .i_data1 (data1),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (head)
    );

    // unpack the queue head: kind, start, length, overflow, last-of-run
    assign o_token_kind      = head[DATA_BITS-1 -: 3];
    assign o_start_position  = head[LENGTH_BITS+2 +: POSITION_BITS];
    assign o_token_length    = head[2 +: LENGTH_BITS];
    assign o_length_overflow = head[1];
    assign o_last_of_run     = head[0];

endmodule

// File: sv/exlex_core.sv
// Lexer state and per-byte token decision; emits up to two packed results.
// Depends on exlex_pkg.
module exlex_core import exlex_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    localparam int DATA_BITS    = 3 + POSITION_BITS + LENGTH_BITS + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_char_code,
    input  logic                 i_final_byte,
    output t_push                o_push,
    output logic [DATA_BITS-1:0] o_data0,
    output logic [DATA_BITS-1:0] o_data1
);

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_IDENT, MODE_WS, MODE_INT, MODE_FLOAT
    } t_mode;

    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [LENGTH_BITS-1:0]   r_len, n_len;
    logic                     r_ovf, n_ovf;
    logic [POSITION_BITS-1:0] r_pos, n_pos;

    logic                     fits, starter, e_old, e_new;
    t_kind                    old_kind, new_kind;
    logic [LENGTH_BITS-1:0]   old_len;
    logic                     old_ovf;

    function automatic t_kind mode_kind(input t_mode m);
        t_kind k;
        unique case (m)
            MODE_IDENT: k = K_IDENT;
            MODE_WS:    k = K_WS;
            MODE_INT:   k = K_INT;
            default:    k = K_FLOAT;
        endcase
        return k;
    endfunction

    always_comb begin
        unique case (r_mode)
            MODE_IDENT: fits = is_ident_tail(i_char_code);
            MODE_WS:    fits = is_blank(i_char_code);
            MODE_INT:   fits = is_digit(i_char_code) || i_char_code == CH_DOT;
            MODE_FLOAT: fits = is_digit(i_char_code);
            default:    fits = 1'b0;
        endcase
        starter  = is_alpha(i_char_code) || is_blank(i_char_code) || is_digit(i_char_code);
        n_mode   = r_mode;
        n_start  = r_start;
        n_len    = r_len;
        n_ovf    = r_ovf;
        e_old    = 1'b0;
        e_new    = 1'b0;
        old_kind = mode_kind(r_mode);
        old_len  = r_len;
        old_ovf  = r_ovf;
        new_kind = K_UNREC;
        if (r_mode != MODE_IDLE && fits) begin
            // extend the open token
            if (r_mode == MODE_INT && i_char_code == CH_DOT) begin
                n_mode = MODE_FLOAT;
            end
            if (&r_len) begin
                n_ovf = 1'b1;
            end else begin
                n_len = r_len + LEN_ONE;
            end
            if (i_final_byte) begin
                e_old    = 1'b1;
                old_kind = mode_kind(n_mode);
                old_len  = n_len;
                old_ovf  = n_ovf;
                n_mode   = MODE_IDLE;
            end
        end else begin
            if (r_mode != MODE_IDLE) begin
                e_old  = 1'b1;
                n_mode = MODE_IDLE;
            end
            if (starter) begin
                n_mode   = is_alpha(i_char_code) ? MODE_IDENT :
                           (is_blank(i_char_code) ? MODE_WS : MODE_INT);
                n_start  = r_pos;
                n_len    = LEN_ONE;
                n_ovf    = 1'b0;
                new_kind = mode_kind(n_mode);
                if (i_final_byte) begin
                    e_new  = 1'b1;
                    n_mode = MODE_IDLE;
                end
            end else begin
                e_new = 1'b1;
                unique case (i_char_code)
                    CH_LPAREN: new_kind = K_LPAREN;
                    CH_RPAREN: new_kind = K_RPAREN;
                    CH_COMMA:  new_kind = K_COMMA;
                    default:   new_kind = K_UNREC;
                endcase
            end
        end
        n_pos = i_final_byte ? '0 : r_pos + POSITION_BITS'(1);
    end

    assign o_push.first  = i_take && (e_old || e_new);
    assign o_push.second = i_take && e_old && e_new;
    assign o_data0 = e_old ? {old_kind, r_start, old_len, old_ovf, !e_new}
                           : {new_kind, r_pos, LEN_ONE, 1'b0, 1'b1};
    assign o_data1 = {new_kind, r_pos, LEN_ONE, 1'b0, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_pos   <= '0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_pos   <= n_pos;
        end
    end

endmodule

// File: sv/exlex_fifo.sv
// Result queue: up to two results in per cycle, one out per ready cycle.
// Depends on exlex_pkg and expression_lexer_macros.svh.
`include "expression_lexer_macros.svh"
module exlex_fifo import exlex_pkg::*; #(
    parameter int DATA_BITS = 53
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_push                i_push,
    input  logic [DATA_BITS-1:0] i_data0,
    input  logic [DATA_BITS-1:0] i_data1,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [DATA_BITS-1:0] o_data
);

    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] ROOM_LIMIT = CNT_BITS'(FIFO_DEPTH - 2);
    localparam logic [CNT_BITS-1:0] FULL_CNT   = CNT_BITS'(FIFO_DEPTH);

    logic [DATA_BITS-1:0] r_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                 pop;

    assign o_valid = r_cnt != '0;
    assign o_room  = r_cnt <= ROOM_LIMIT;
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr  = r_wr + PTR_BITS'(i_push.first) + PTR_BITS'(i_push.second);
        n_rd  = r_rd + PTR_BITS'(pop);
        n_cnt = r_cnt + CNT_BITS'(i_push.first) + CNT_BITS'(i_push.second)
              - CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push.second) begin
            r_mem[r_wr + PTR_BITS'(1)] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    `EXLEX_NEVER(a_cnt_bound, i_clk, i_rst_n, r_cnt > FULL_CNT)
    `EXLEX_ASSERT(a_second_needs_first, i_clk, i_rst_n, i_push.second |-> i_push.first)
    `EXLEX_ASSERT(a_push_has_room, i_clk, i_rst_n, i_push.first |-> o_room)
    `EXLEX_ASSERT(a_ptr_track, i_clk, i_rst_n,
                  (r_wr - r_rd) == PTR_BITS'(r_cnt))

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for expression_lexer: scripted text, then random texts.
// Depends on exlex_pkg and the expression_lexer RTL; every token is predicted here.
module tb_top;
    import exlex_pkg::*;

    localparam int PB = POSITION_BITS_DEF;
    localparam int LB = LENGTH_BITS_DEF;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_BYTES = 600;

    // Lexer state as this bench tracks it.
    typedef enum logic [2:0] {
        LX_IDLE, LX_IDENT, LX_BLANK, LX_INT, LX_FLOAT
    } t_lex_mode;

    // Byte classes the token rules care about.
    typedef enum logic [3:0] {
        CL_LETTER, CL_DIGIT, CL_BLANK, CL_DOT, CL_JOIN,
        CL_LPAREN, CL_RPAREN, CL_COMMA, CL_OTHER
    } t_char_class;

    typedef struct packed {
        t_kind         kind;
        logic [PB-1:0] start;
        logic [LB-1:0] len;
        logic          ovf;
        logic          last;
    } t_token;

    // One line of the scripted text: a byte repeated reps times. Where typed is
    // set, the first token that the last repetition emits is spelled out.
    typedef struct {
        logic [7:0]    ch;
        logic          fin;
        int unsigned   reps;
        bit            typed;
        t_kind         kind;
        int unsigned   start;
        int unsigned   len;
        logic          ovf;
    } t_script_line;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic [7:0]    i_char_code = '0;
    logic          i_final_byte = 1'b0;
    logic          i_ready = 1'b0;
    logic          o_ready;
    logic          o_valid;
    logic [2:0]    o_token_kind;
    logic [PB-1:0] o_start_position;
    logic [LB-1:0] o_token_length;
    logic          o_length_overflow;
    logic          o_last_of_run;

    // Predicted lexer state.
    t_lex_mode     lex_mode = LX_IDLE;
    logic [PB-1:0] tok_start = '0;
    logic [LB-1:0] tok_len = '0;
    logic          tok_ovf = 1'b0;
    logic [PB-1:0] byte_pos = '0;

    t_token        pending_tokens[$];
    int unsigned   byte_first_idx;
    int unsigned   token_errors = 0;
    int unsigned   cycle_count = 0;
    int unsigned   burst_left = 0;
    int unsigned   items_sent = 0;
    logic [9:0]    stall_phase = '0;

    // Scripted text: every token kind, both ends of the ident set, a float cut
    // by a second dot, bytes outside ASCII, one-byte tokens on the final byte,
    // a short whitespace run and an identifier closed by a dot on the final
    // byte.
    t_script_line script [29] = '{
        '{CH_LPAREN, 1'b0, 1,     1'b1, K_LPAREN, 0,     1,     1'b0},
        '{"a",       1'b0, 1,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{"Z",       1'b0, 1,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{CH_UNDER,  1'b0, 1,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{CH_DASH,   1'b0, 1,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{"9",       1'b0, 1,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{CH_RPAREN, 1'b0, 1,     1'b1, K_IDENT,  1,     5,     1'b0},
        '{CH_COMMA,  1'b0, 1,     1'b1, K_COMMA,  7,     1,     1'b0},
        '{CH_SPACE,  1'b0, 1,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{CH_TAB,    1'b0, 1,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{"0",       1'b0, 1,     1'b1, K_WS,     8,     2,     1'b0},
        '{"7",       1'b0, 1,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{CH_DOT,    1'b0, 1,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{"5",       1'b0, 1,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{CH_DOT,    1'b0, 1,     1'b1, K_FLOAT,  10,    4,     1'b0},
        '{8'h00,     1'b0, 1,     1'b1, K_UNREC,  15,    1,     1'b0},
        '{8'hFF,     1'b0, 1,     1'b1, K_UNREC,  16,    1,     1'b0},
        '{"1",       1'b0, 1,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{"x",       1'b0, 1,     1'b1, K_INT,    17,    1,     1'b0},
        '{"q",       1'b1, 1,     1'b1, K_IDENT,  18,    2,     1'b0},
        '{"5",       1'b1, 1,     1'b1, K_INT,    0,     1,     1'b0},
        '{CH_SPACE,  1'b0, 3,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{"b",       1'b0, 1,     1'b1, K_WS,     0,     3,     1'b0},
        '{"c",       1'b0, 3,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{CH_DOT,    1'b1, 1,     1'b1, K_IDENT,  3,     4,     1'b0},
        '{"3",       1'b0, 1,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{CH_DOT,    1'b0, 1,     1'b0, K_UNREC,  0,     0,     1'b0},
        '{"4",       1'b1, 1,     1'b1, K_FLOAT,  0,     3,     1'b0},
        '{CH_DASH,   1'b1, 1,     1'b1, K_UNREC,  0,     1,     1'b0}
    };

    expression_lexer #(
        .POSITION_BITS(PB),
        .LENGTH_BITS  (LB)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_char_code      (i_char_code),
        .i_final_byte     (i_final_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_token_kind     (o_token_kind),
        .o_start_position (o_start_position),
        .o_token_length   (o_token_length),
        .o_length_overflow(o_length_overflow),
        .o_last_of_run    (o_last_of_run)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_char_class classify(input logic [7:0] ch);
        if ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")) return CL_LETTER;
        if (ch >= "0" && ch <= "9") return CL_DIGIT;
        case (ch)
            CH_SPACE, CH_TAB:  return CL_BLANK;
            CH_DOT:            return CL_DOT;
            CH_UNDER, CH_DASH: return CL_JOIN;
            CH_LPAREN:         return CL_LPAREN;
            CH_RPAREN:         return CL_RPAREN;
            CH_COMMA:          return CL_COMMA;
            default:           return CL_OTHER;
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        int unsigned x;
        x = $urandom_range(0, 51);
        return (x < 26) ? 8'("A" + x) : 8'("a" + x - 26);
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // Emit the open token and go back to idle.
    task automatic close_token();
        t_token tok;
        case (lex_mode)
            LX_IDENT: tok.kind = K_IDENT;
            LX_BLANK: tok.kind = K_WS;
            LX_INT:   tok.kind = K_INT;
            default:  tok.kind = K_FLOAT;
        endcase
        tok.start = tok_start;
        tok.len   = tok_len;
        tok.ovf   = tok_ovf;
        tok.last  = 1'b0;
        pending_tokens = {pending_tokens, tok};
        lex_mode = LX_IDLE;
    endtask

    // Advance the predicted lexer by one accepted byte and queue its tokens.
    task automatic lex_byte(input logic [7:0] ch, input logic fin);
        t_char_class cls;
        logic        fits;
        t_token      tok;
        cls = classify(ch);
        byte_first_idx = pending_tokens.size();
        case (lex_mode)
            LX_IDENT: fits = cls == CL_LETTER || cls == CL_DIGIT || cls == CL_JOIN;
            LX_BLANK: fits = cls == CL_BLANK;
            LX_INT:   fits = cls == CL_DIGIT || cls == CL_DOT;
            LX_FLOAT: fits = cls == CL_DIGIT;
            default:  fits = 1'b0;
        endcase
        if (lex_mode != LX_IDLE && fits) begin
            // The first dot turns an integer into a float.
            if (lex_mode == LX_INT && cls == CL_DOT) lex_mode = LX_FLOAT;
            if (&tok_len) tok_ovf = 1'b1;
            else tok_len = tok_len + 1'b1;
            if (fin) close_token();
        end else begin
            if (lex_mode != LX_IDLE) close_token();
            if (cls == CL_LETTER || cls == CL_BLANK || cls == CL_DIGIT) begin
                lex_mode  = (cls == CL_LETTER) ? LX_IDENT :
                            (cls == CL_BLANK) ? LX_BLANK : LX_INT;
                tok_start = byte_pos;
                tok_len   = LB'(1);
                tok_ovf   = 1'b0;
                if (fin) close_token();
            end else begin
                case (cls)
                    CL_LPAREN: tok.kind = K_LPAREN;
                    CL_RPAREN: tok.kind = K_RPAREN;
                    CL_COMMA:  tok.kind = K_COMMA;
                    default:   tok.kind = K_UNREC;
                endcase
                tok.start = byte_pos;
                tok.len   = LB'(1);
                tok.ovf   = 1'b0;
                tok.last  = 1'b0;
                pending_tokens = {pending_tokens, tok};
            end
        end
        // Flag the last token this byte produced.
        if (pending_tokens.size() > byte_first_idx) begin
            tok = pending_tokens[$];
            tok.last = 1'b1;
            pending_tokens[$] = tok;
        end
        byte_pos = fin ? '0 : byte_pos + 1'b1;
    endtask

    // Offer one byte and hold it until accepted. Outside steady runs the
    // sender works in bursts with idle gaps between them.
    task automatic send_byte(input logic [7:0] ch, input logic fin, input bit steady);
        int unsigned gap;
        if (!steady) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        i_valid      <= 1'b1;
        i_char_code  <= ch;
        i_final_byte <= fin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        lex_byte(ch, fin);
    endtask

    // One random text, mostly well-formed tokens, closed by a final byte.
    task automatic send_text();
        logic [7:0]  text[$];
        int unsigned pick;
        repeat ($urandom_range(1, 10)) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                text = {text, pick_letter()};
                repeat ($urandom_range(0, 10)) begin
                    case ($urandom_range(0, 5))
                        0:       text = {text, CH_UNDER};
                        1:       text = {text, CH_DASH};
                        2:       text = {text, pick_digit()};
                        default: text = {text, pick_letter()};
                    endcase
                end
            end else if (pick < 45) begin
                repeat ($urandom_range(1, 6)) text = {text, pick_digit()};
                if (pick >= 35) begin
                    text = {text, CH_DOT};
                    repeat ($urandom_range(0, 5)) text = {text, pick_digit()};
                end
            end else if (pick < 58) begin
                repeat ($urandom_range(1, 5))
                    text = {text, ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB};
            end else if (pick < 78) begin
                case ($urandom_range(0, 2))
                    0:       text = {text, CH_LPAREN};
                    1:       text = {text, CH_RPAREN};
                    default: text = {text, CH_COMMA};
                endcase
            end else if (pick < 86) begin
                // A stray dot; right after a float it acts as a second dot.
                text = {text, CH_DOT};
            end else begin
                text = {text, 8'($urandom_range(0, 255))};
            end
        end
        foreach (text[i]) send_byte(text[i], i == text.size() - 1, 1'b0);
        items_sent += text.size();
    endtask

    function automatic void match(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
        if (want !== got) begin
            token_errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    // Receiver: cycles through always ready, light stalls, long regular stalls
    // and heavy random stalls.
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[9:8])
            2'd0:    i_ready <= 1'b1;
            2'd1:    i_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    i_ready <= (stall_phase[3:0] < 4);
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Check every accepted token against the oldest prediction.
    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_tokens.size() == 0) begin
                token_errors++;
                $display("%0t: token with none predicted, kind %0d start %0h len %0h",
                         $time, o_token_kind, o_start_position, o_token_length);
            end else begin
                want = pending_tokens.pop_front();
                match("token_kind", 64'(want.kind), 64'(o_token_kind));
                match("start_position", 64'(want.start), 64'(o_start_position));
                match("token_length", 64'(want.len), 64'(o_token_length));
                match("length_overflow", 64'(want.ovf), 64'(o_length_overflow));
                match("last_of_run", 64'(want.last), 64'(o_last_of_run));
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_token tok;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Scripted part: repeated bytes go without gaps.
        foreach (script[r]) begin
            repeat (script[r].reps) send_byte(script[r].ch, script[r].fin, script[r].reps > 1);
            if (script[r].typed && pending_tokens.size() > byte_first_idx) begin
                tok       = pending_tokens[byte_first_idx];
                tok.kind  = script[r].kind;
                tok.start = PB'(script[r].start);
                tok.len   = LB'(script[r].len);
                tok.ovf   = script[r].ovf;
                pending_tokens[byte_first_idx] = tok;
            end
        end

        // Random part: mostly texts, now and then raw noise bytes.
        while (items_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 8)) begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0);
                    items_sent++;
                end
            end else begin
                send_text();
            end
        end
        i_valid <= 1'b0;

        // Drain, then give the block time to show any stray token.
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (token_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
